FILE: sv/twdb_pkg.sv
`timescale 1ns / 1ps

package twdb_pkg;

    localparam int QP_W = 16;
    localparam int PC_W = 4;
    localparam int BIT_CNT_W = 3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DSEL_REL,
        DSEL_DRIVE,
        DSEL_BIT
    } dsel_t;

    typedef enum logic [1:0] {
        CSEL_REL,
        CSEL_DRIVE,
        CSEL_HELD
    } csel_t;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_LOOP,
        OP_END
    } op_t;

    localparam logic [PC_W-1:0] ENTRY_START = 4'd0;
    localparam logic [PC_W-1:0] ENTRY_STOP  = 4'd3;
    localparam logic [PC_W-1:0] ENTRY_WRITE = 4'd6;
    localparam logic [PC_W-1:0] ENTRY_BIT   = 4'd6;

    typedef struct packed {
        dsel_t           dsel;
        csel_t           csel;
        logic            last;
        op_t             op;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic  load;
        logic  issue;
        logic  shift;
        dsel_t dsel;
        csel_t csel;
        logic  last;
    } dp_ctrl_t;

    typedef struct packed {
        logic out_free;
        logic bit_last;
    } dp_stat_t;

endpackage

FILE: sv/twdb_ucode_rom.sv
`timescale 1ns / 1ps

module twdb_ucode_rom
    import twdb_pkg::*;
(
    input  logic [PC_W-1:0] addr,
    output uword_t          word
);

    always_comb
    begin
        word = '{dsel: DSEL_REL, csel: CSEL_REL, last: 1'b1, op: OP_END, target: '0};
        unique case (addr)
            // start: data falls while clock released
            4'd0:  word = '{DSEL_REL,   CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd1:  word = '{DSEL_DRIVE, CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd2:  word = '{DSEL_DRIVE, CSEL_DRIVE, 1'b1, OP_END,  '0};
            // stop: data rises while clock released
            4'd3:  word = '{DSEL_DRIVE, CSEL_DRIVE, 1'b0, OP_NEXT, '0};
            4'd4:  word = '{DSEL_DRIVE, CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd5:  word = '{DSEL_REL,   CSEL_REL,   1'b1, OP_END,  '0};
            // byte bits, lsb first
            4'd6:  word = '{DSEL_BIT,   CSEL_HELD,  1'b0, OP_NEXT, '0};
            4'd7:  word = '{DSEL_BIT,   CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd8:  word = '{DSEL_BIT,   CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd9:  word = '{DSEL_BIT,   CSEL_DRIVE, 1'b0, OP_LOOP, ENTRY_BIT};
            // ack clock, data released
            4'd10: word = '{DSEL_REL,   CSEL_HELD,  1'b0, OP_NEXT, '0};
            4'd11: word = '{DSEL_REL,   CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd12: word = '{DSEL_REL,   CSEL_REL,   1'b0, OP_NEXT, '0};
            4'd13: word = '{DSEL_REL,   CSEL_DRIVE, 1'b1, OP_END,  '0};
            default: word = '{DSEL_REL, CSEL_REL,   1'b1, OP_END,  '0};
        endcase
    end

endmodule

FILE: sv/twdb_seq.sv
`timescale 1ns / 1ps

module twdb_seq
    import twdb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      command,
    input  logic            cfg_we,
    input  logic [QP_W-1:0] cfg_wdata,
    input  uword_t          uw,
    output logic [PC_W-1:0] pc,
    input  dp_stat_t        stat,
    output dp_ctrl_t        ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    logic [QP_W-1:0] timer_reg, timer_next;
    logic [QP_W-1:0] qp_reg;
    logic            in_fire;
    logic            issue;

    assign pc       = pc_reg;
    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign issue    = busy_reg && (timer_reg == '0) && stat.out_free;

    always_comb
    begin
        pc_next    = pc_reg;
        busy_next  = busy_reg;
        timer_next = timer_reg;
        ctrl.load  = 1'b0;
        ctrl.issue = issue;
        ctrl.shift = 1'b0;
        ctrl.dsel  = uw.dsel;
        ctrl.csel  = uw.csel;
        ctrl.last  = uw.last;

        if (issue)
        begin
            timer_next = (qp_reg == '0) ? '0 : qp_reg - 1'b1;
        end
        else if (timer_reg != '0)
        begin
            timer_next = timer_reg - 1'b1;
        end

        if (issue)
        begin
            unique case (uw.op)
                OP_NEXT: pc_next = pc_reg + 1'b1;
                OP_LOOP:
                begin
                    if (stat.bit_last)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        pc_next    = uw.target;
                        ctrl.shift = 1'b1;
                    end
                end
                OP_END:  busy_next = 1'b0;
                default: busy_next = 1'b0;
            endcase
        end

        if (in_fire)
        begin
            unique case (cmd_t'(command))
                CMD_START:
                begin
                    pc_next   = ENTRY_START;
                    busy_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    pc_next   = ENTRY_WRITE;
                    busy_next = 1'b1;
                    ctrl.load = 1'b1;
                end
                CMD_STOP:
                begin
                    pc_next   = ENTRY_STOP;
                    busy_next = 1'b1;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            busy_reg  <= 1'b0;
            timer_reg <= '0;
            qp_reg    <= 16'd25;
        end
        else
        begin
            pc_reg    <= pc_next;
            busy_reg  <= busy_next;
            timer_reg <= timer_next;
            if (cfg_we)
            begin
                qp_reg <= cfg_wdata;
            end
        end
    end

endmodule

FILE: sv/twdb_datapath.sv
`timescale 1ns / 1ps

module twdb_datapath
    import twdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  dp_ctrl_t   ctrl,
    output dp_stat_t   stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       data_low,
    output logic       clock_low,
    output logic       last_phase
);

    logic [7:0]           shift_reg;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic                 held_reg;
    logic                 valid_reg;
    logic                 dlow_reg, clow_reg, last_reg;
    logic                 dlow_next, clow_next;

    assign stat.out_free = !valid_reg || out_ready;
    assign stat.bit_last = (cnt_reg == {BIT_CNT_W{1'b1}});

    always_comb
    begin
        case (ctrl.dsel)
            DSEL_DRIVE: dlow_next = 1'b1;
            DSEL_BIT:   dlow_next = ~shift_reg[0];
            default:    dlow_next = 1'b0;
        endcase
        case (ctrl.csel)
            CSEL_DRIVE: clow_next = 1'b1;
            CSEL_HELD:  clow_next = held_reg;
            default:    clow_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            held_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (ctrl.issue)
            begin
                valid_reg <= 1'b1;
                held_reg  <= clow_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (ctrl.load)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            shift_reg <= data_byte;
        end
        else if (ctrl.shift)
        begin
            shift_reg <= {1'b0, shift_reg[7:1]};
        end
        if (ctrl.issue)
        begin
            dlow_reg <= dlow_next;
            clow_reg <= clow_next;
            last_reg <= ctrl.last;
        end
    end

    assign out_valid  = valid_reg;
    assign data_low   = dlow_reg;
    assign clock_low  = clow_reg;
    assign last_phase = last_reg;

endmodule

FILE: sv/two_wire_display_bus_writer_unit.sv
`timescale 1ns / 1ps
// two-wire led-driver bus master, lsb first, open-drain pins
// input channel: one word per bus command (command, data_byte);
//   start and stop give 3 result words, a byte write gives 36
// output channel: one word per quarter phase (data_low, clock_low,
//   last_phase); last_phase marks the final phase of a command
// config: cfg_we / cfg_wdata writes quarter_period (reset 25)
// phases are paced by a quarter_period timer: a new phase is issued
//   once the timer, reloaded from quarter_period at each issue, has run
//   out and the output register is free
// first result: busy flag, then output register, once timer has run out
// in_ready is high while no command is in progress; one command at a time
// command code 3 is accepted and dropped without results
// a stalled receiver holds the current word; the microcode step counter
//   waits until the output register frees
// reset: sequencer idle, clock drive level cleared, no word pending
module two_wire_display_bus_writer_unit
    import twdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        data_low,
    output logic        clock_low,
    output logic        last_phase,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [PC_W-1:0] pc;
    uword_t          uw;
    dp_ctrl_t        ctrl;
    dp_stat_t        stat;

    twdb_ucode_rom u_rom (
        .addr (pc),
        .word (uw)
    );

    twdb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .uw        (uw),
        .pc        (pc),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    twdb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_low   (data_low),
        .clock_low  (clock_low),
        .last_phase (last_phase)
    );

endmodule
